### hw/rtl/teq_pkg.sv
package teq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS = 40;
  localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
  localparam int RANK_BITS = SLOT_BITS + 1;
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_BITS = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] KIND_FIRED = 3'd0;
  localparam logic [2:0] KIND_ADDED = 3'd1;
  localparam logic [2:0] KIND_FULL = 3'd2;
  localparam logic [2:0] KIND_REMOVED = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;

  localparam logic REG_DELIVER = 1'b0;
  localparam logic REG_DEDUP = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;

  // Running best of a scan: earliest (target, rank) seen so far.
  typedef struct packed {
    logic found;
    logic [SLOT_BITS-1:0] slot;
    time_t target;
    logic [RANK_BITS-1:0] rank;
  } best_t;
endpackage

### hw/rtl/teq_scan.sv
// One-slot-per-cycle compare unit: keeps the earliest candidate seen so far.
module teq_scan
  import teq_pkg::*;
(
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 cand,
  input  logic [SLOT_BITS-1:0] slot,
  input  time_t                target,
  input  logic [RANK_BITS-1:0] rank,
  output best_t                best
);
  logic better;

  assign better = cand && (!best.found || target < best.target ||
                  (target == best.target && rank < best.rank));

  always_ff @(posedge clk) begin
    if (clear) begin
      best.found <= 1'b0;
      best.slot <= '0;
      best.target <= '0;
      best.rank <= '0;
    end else if (better) begin
      best <= '{found: 1'b1, slot: slot, target: target, rank: rank};
    end
  end
endmodule

### hw/rtl/timed_event_queue.sv
// Channel   | Signals                                              | Direction
// command   | start, busy, operation, event_type, delay_ms,         | in, busy out
//           | repeat_flag, payload_tag                              |
// result    | result_valid, result_kind, fired_type, fired_payload, | out
//           | last_of_run                                           |
// config    | cfg_we, cfg_index, cfg_data                           | in
// An add or remove runs a slot scan, a rank fix when it drops an event, an update
// and a result. A tick repeats a scan and a rank fix for each firing, then a final
// scan and the result; the single compare unit walks one slot each cycle.
// rst clears the clock, the valid bits and deliver_enable and sets the dedup mask to 7; tables are not cleared.
// Each result beat is shown for one cycle; the receiver cannot stall.
module timed_event_queue
  import teq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [3:0]  event_type,
  input  logic [31:0] delay_ms,
  input  logic        repeat_flag,
  input  logic [15:0] payload_tag,
  output logic        result_valid,
  output logic [2:0]  result_kind,
  output logic [3:0]  fired_type,
  output logic [15:0] fired_payload,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT = 3'd2;
  localparam logic [2:0] S_RANK = 3'd3;
  localparam logic [2:0] S_PUT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;
  logic deliver_enable;
  logic [15:0] dedup_type_mask;
  time_t clock_ms;

  logic [QUEUE_DEPTH-1:0] entry_valid;
  logic [QUEUE_DEPTH-1:0] done;
  logic [3:0] entry_type [QUEUE_DEPTH];
  time_t entry_target [QUEUE_DEPTH];
  logic [31:0] entry_period [QUEUE_DEPTH];
  logic entry_repeat [QUEUE_DEPTH];
  logic [15:0] entry_payload [QUEUE_DEPTH];
  logic [RANK_BITS-1:0] entry_order [QUEUE_DEPTH];

  logic [1:0] op;
  logic [3:0] typ;
  logic [31:0] delay;
  logic rep;
  logic [15:0] pay;
  logic [RANK_BITS:0] cnt;
  logic [RANK_BITS:0] idx;
  logic [FIRE_BITS-1:0] fires;
  logic pend_valid;
  logic [2:0] pend_kind;
  logic [3:0] pend_type;
  logic [15:0] pend_pay;
  logic [RANK_BITS-1:0] gap_rank;

  logic [SLOT_BITS-1:0] sidx;
  logic scan_clear;
  logic cand;
  best_t best;

  assign sidx = idx[SLOT_BITS-1:0];
  assign busy = (state != S_IDLE);

  always_comb begin
    cand = 1'b0;
    if (state == S_SCAN && entry_valid[sidx]) begin
      if (op == OP_TICK)
        cand = !done[sidx] && entry_target[sidx] <= clock_ms;
      else
        cand = entry_type[sidx] == typ && dedup_type_mask[typ];
    end
  end

  teq_scan u_scan (
    .clk(clk), .clear(scan_clear), .cand(cand), .slot(sidx),
    .target(entry_target[sidx]), .rank(entry_order[sidx]), .best(best)
  );

  function automatic time_t sat_add(time_t a, logic [32:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {{(TIME_BITS - 32){1'b0}}, d};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  logic [SLOT_BITS-1:0] free_slot;
  logic free_found;
  always_comb begin
    free_slot = '0;
    free_found = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
      if (!entry_valid[i]) begin
        free_slot = SLOT_BITS'(i);
        free_found = 1'b1;
      end
  end

  // hold the winner through the rank fix; drop it before the next tick scan
  assign scan_clear = (state == S_IDLE) ||
                      (state == S_RANK && op == OP_TICK &&
                       idx == (RANK_BITS + 1)'(QUEUE_DEPTH - 1));

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    last_of_run <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      deliver_enable <= 1'b0;
      dedup_type_mask <= 16'd7;
      clock_ms <= '0;
      entry_valid <= '0;
      cnt <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we && state == S_IDLE) begin
        if (cfg_index == REG_DELIVER) deliver_enable <= cfg_data[0];
        else dedup_type_mask <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          done <= '0;
          fires <= '0;
          pend_valid <= 1'b0;
          if (start) begin
            op <= operation;
            typ <= event_type;
            delay <= delay_ms;
            rep <= repeat_flag;
            pay <= payload_tag;
            if (operation == OP_TICK) begin
              clock_ms <= sat_add(clock_ms, 33'd1);
              state <= S_SCAN;
            end else if (operation == OP_ADD || operation == OP_REMOVE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == (RANK_BITS + 1)'(QUEUE_DEPTH - 1)) state <= S_ACT;
        end
        S_ACT: begin
          idx <= '0;
          if (op == OP_TICK) begin
            if (!best.found || fires == FIRE_BITS'(MAX_RESULTS)) begin
              state <= S_EMIT;
            end else begin
              done[best.slot] <= 1'b1;
              fires <= fires + 1'b1;
              if (deliver_enable) begin
                if (pend_valid) begin
                  result_valid <= 1'b1;
                  result_kind <= pend_kind;
                  fired_type <= pend_type;
                  fired_payload <= pend_pay;
                end
                pend_valid <= 1'b1;
                pend_kind <= KIND_FIRED;
                pend_type <= entry_type[best.slot];
                pend_pay <= entry_payload[best.slot];
              end
              gap_rank <= best.rank;
              if (entry_repeat[best.slot]) begin
                entry_order[best.slot] <= RANK_BITS'(cnt - 1'b1);
                entry_target[best.slot] <=
                  sat_add(clock_ms, {1'b0, entry_period[best.slot]});
                entry_payload[best.slot] <= '0;
              end else begin
                entry_valid[best.slot] <= 1'b0;
                cnt <= cnt - 1'b1;
              end
              state <= S_RANK;
            end
          end else begin
            if (best.found) begin
              entry_valid[best.slot] <= 1'b0;
              cnt <= cnt - 1'b1;
              gap_rank <= best.rank;
              state <= S_RANK;
            end else begin
              state <= S_PUT;
            end
          end
        end
        S_RANK: begin
          // close the rank gap one slot a cycle
          if (entry_valid[sidx] && !(sidx == best.slot && op == OP_TICK) &&
              entry_order[sidx] > gap_rank)
            entry_order[sidx] <= entry_order[sidx] - 1'b1;
          idx <= idx + 1'b1;
          if (idx == (RANK_BITS + 1)'(QUEUE_DEPTH - 1)) begin
            idx <= '0;
            state <= (op == OP_TICK) ? S_SCAN : S_PUT;
          end
        end
        S_PUT: begin
          pend_valid <= 1'b1;
          pend_type <= typ;
          pend_pay <= '0;
          if (op == OP_REMOVE) begin
            pend_kind <= best.found ? KIND_REMOVED : KIND_NONE;
          end else if (!free_found) begin
            pend_kind <= KIND_FULL;
          end else begin
            pend_kind <= KIND_ADDED;
            entry_valid[free_slot] <= 1'b1;
            entry_order[free_slot] <= RANK_BITS'(cnt);
            entry_type[free_slot] <= typ;
            entry_target[free_slot] <= sat_add(clock_ms, {1'b0, delay});
            entry_period[free_slot] <= delay;
            entry_repeat[free_slot] <= rep;
            entry_payload[free_slot] <= pay;
            cnt <= cnt + 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (pend_valid) begin
            result_valid <= 1'b1;
            result_kind <= pend_kind;
            fired_type <= pend_type;
            fired_payload <= pend_pay;
            last_of_run <= 1'b1;
          end
          pend_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sim/timed_event_queue_test.sv
module timed_event_queue_test;
  import teq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  // longest silent stretch: a full tick scan with every slot firing
  localparam int SETTLE_CYCLES = (2 * QUEUE_DEPTH + 1) * (MAX_RESULTS + 1) + 20;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  etype;
    logic [15:0] payload;
    logic        last;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [3:0]  event_type;
  logic [31:0] delay_ms;
  logic        repeat_flag;
  logic [15:0] payload_tag;
  logic        result_valid;
  logic [2:0]  result_kind;
  logic [3:0]  fired_type;
  logic [15:0] fired_payload;
  logic        last_of_run;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  timed_event_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .event_type(event_type), .delay_ms(delay_ms),
    .repeat_flag(repeat_flag), .payload_tag(payload_tag),
    .result_valid(result_valid), .result_kind(result_kind),
    .fired_type(fired_type), .fired_payload(fired_payload),
    .last_of_run(last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the event table
  bit          deliver_on;
  logic [15:0] dedup_mask;
  time_t       now_ms;
  bit          slot_used [QUEUE_DEPTH];
  logic [3:0]  slot_type [QUEUE_DEPTH];
  time_t       slot_target [QUEUE_DEPTH];
  logic [31:0] slot_period [QUEUE_DEPTH];
  bit          slot_repeat [QUEUE_DEPTH];
  logic [15:0] slot_payload [QUEUE_DEPTH];
  int          slot_rank [QUEUE_DEPTH];

  outcome_t pending_q[$];
  outcome_t want;
  int       errors;
  bit       no_gaps;

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic time_t sat_sum(time_t base, logic [31:0] delta);
    logic [TIME_BITS:0] s;
    s = base + delta;
    if (s[TIME_BITS]) return '1;
    return s[TIME_BITS-1:0];
  endfunction

  function automatic bit ahead(int a, int b);
    if (slot_target[a] != slot_target[b]) return slot_target[a] < slot_target[b];
    return slot_rank[a] < slot_rank[b];
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  function automatic int oldest_of(logic [3:0] t);
    int best;
    best = -1;
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i] && slot_type[i] == t && (best < 0 || ahead(i, best))) best = i;
    return best;
  endfunction

  // close the rank gap left by slot s
  function automatic void close_gap(int s);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      if (slot_used[i] && i != s && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
  endfunction

  function automatic void retire(int s);
    close_gap(s);
    slot_used[s] = 0;
  endfunction

  function automatic void predict_outcomes(logic [1:0] op, logic [3:0] t, logic [31:0] d,
                                           logic r, logic [15:0] p);
    outcome_t batch[$];
    bit fired [QUEUE_DEPTH];
    int s;
    bit marked;
    marked = dedup_mask[t];
    for (int i = 0; i < QUEUE_DEPTH; i++) fired[i] = 0;
    case (op)
      OP_TICK: begin
        now_ms = sat_sum(now_ms, 32'd1);
        for (int f = 0; f < MAX_RESULTS; f++) begin
          s = -1;
          for (int i = 0; i < QUEUE_DEPTH; i++)
            if (slot_used[i] && !fired[i] && slot_target[i] <= now_ms &&
                (s < 0 || ahead(i, s))) s = i;
          if (s < 0) break;
          fired[s] = 1;
          if (deliver_on) batch.push_back('{KIND_FIRED, slot_type[s], slot_payload[s], 1'b0});
          if (slot_repeat[s]) begin
            close_gap(s);
            slot_rank[s] = used_count() - 1;
            slot_target[s] = sat_sum(now_ms, slot_period[s]);
            slot_payload[s] = '0;
          end else begin
            retire(s);
          end
        end
      end
      OP_ADD: begin
        if (marked) begin
          s = oldest_of(t);
          if (s >= 0) retire(s);
        end
        s = -1;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) if (!slot_used[i]) s = i;
        if (s < 0) begin
          batch.push_back('{KIND_FULL, t, 16'd0, 1'b0});
        end else begin
          slot_rank[s] = used_count();
          slot_used[s] = 1;
          slot_type[s] = t;
          slot_target[s] = sat_sum(now_ms, d);
          slot_period[s] = d;
          slot_repeat[s] = r;
          slot_payload[s] = p;
          batch.push_back('{KIND_ADDED, t, 16'd0, 1'b0});
        end
      end
      OP_REMOVE: begin
        s = marked ? oldest_of(t) : -1;
        if (s >= 0) begin
          retire(s);
          batch.push_back('{KIND_REMOVED, t, 16'd0, 1'b0});
        end else begin
          batch.push_back('{KIND_NONE, t, 16'd0, 1'b0});
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_q.push_back(batch[i]);
  endfunction

  task automatic send_command(logic [1:0] op, logic [3:0] t, logic [31:0] d,
                              logic r, logic [15:0] p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    event_type = t;
    delay_ms = d;
    repeat_flag = r;
    payload_tag = p;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_outcomes(op, t, d, r, p);
  endtask

  // hold until every expected beat is in, then let a silent tick finish
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_DELIVER) deliver_on = data[0];
    else dedup_mask = data;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat kind %0d type %0d", result_kind, fired_type));
      end else begin
        want = pending_q.pop_front();
        if (result_kind !== want.kind)
          report($sformatf("kind %0d, want %0d", result_kind, want.kind));
        if (fired_type !== want.etype)
          report($sformatf("type %0d, want %0d", fired_type, want.etype));
        if (fired_payload !== want.payload)
          report($sformatf("payload %h, want %h", fired_payload, want.payload));
        if (last_of_run !== want.last)
          report($sformatf("last %0b, want %0b", last_of_run, want.last));
      end
    end
  end

  task automatic test_empty_table();
    send_command(OP_REMOVE, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(OP_REMOVE, 4'd9, 32'd0, 1'b0, 16'd0);
    send_command(OP_UNUSED, 4'hf, 32'hffffffff, 1'b1, 16'hffff);
    send_command(OP_TICK, 4'd0, 32'd0, 1'b0, 16'd0);
  endtask

  task automatic test_fire_and_repeat();
    wait_idle();
    write_reg(REG_DELIVER, 16'd1);
    send_command(OP_ADD, 4'd4, 32'd0, 1'b0, 16'hffff);
    send_command(OP_ADD, 4'd5, 32'd2, 1'b1, 16'h1234);
    // zero period: fires once per tick, forever
    send_command(OP_ADD, 4'd6, 32'd0, 1'b1, 16'h0000);
    repeat (4) send_command(OP_TICK, 4'd0, 32'd0, 1'b0, 16'd0);
    send_command(OP_REMOVE, 4'd5, 32'd0, 1'b0, 16'd0);
    wait_idle();
    write_reg(REG_DEDUP, 16'hffff);
    send_command(OP_REMOVE, 4'd5, 32'd0, 1'b0, 16'd0);
    send_command(OP_REMOVE, 4'd6, 32'd0, 1'b0, 16'd0);
  endtask

  task automatic test_dedup();
    send_command(OP_ADD, 4'd1, 32'd10, 1'b0, 16'h0001);
    send_command(OP_ADD, 4'd1, 32'd3, 1'b0, 16'h0002);
    send_command(OP_REMOVE, 4'd1, 32'd0, 1'b0, 16'd0);
    send_command(OP_REMOVE, 4'd1, 32'd0, 1'b0, 16'd0);
    // far target saturates nowhere near, but exercises the top delay bits
    send_command(OP_ADD, 4'd15, 32'hffffffff, 1'b1, 16'hffff);
    send_command(OP_REMOVE, 4'd15, 32'd0, 1'b0, 16'd0);
  endtask

  task automatic test_full_table();
    wait_idle();
    write_reg(REG_DEDUP, 16'h0000);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_command(OP_ADD, i[3:0], 32'd2, i[0], 16'($urandom));
    send_command(OP_ADD, 4'd7, 32'd1, 1'b0, 16'h5555);
    wait_idle();
    write_reg(REG_DEDUP, 16'h0080);
    send_command(OP_ADD, 4'd7, 32'd1, 1'b0, 16'haaaa);
    // equal targets fire in insertion order
    repeat (3) send_command(OP_TICK, 4'd0, 32'd0, 1'b0, 16'd0);
  endtask

  task automatic send_random();
    int pick;
    logic [1:0] op;
    logic [31:0] d;
    pick = $urandom_range(0, 99);
    op = pick < 40 ? OP_TICK : pick < 75 ? OP_ADD : pick < 93 ? OP_REMOVE : OP_UNUSED;
    pick = $urandom_range(0, 99);
    d = pick < 85 ? 32'($urandom_range(0, 12)) : pick < 95 ? $urandom : 32'hffffffff;
    send_command(op, 4'($urandom_range(0, 15)), d, 1'($urandom),
                 $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
  endtask

  task automatic test_random_phase(logic deliver, logic [15:0] mask);
    wait_idle();
    write_reg(REG_DELIVER, {15'd0, deliver});
    write_reg(REG_DEDUP, mask);
    for (int i = 0; i < 95; i++) begin
      if (i % 20 == 0) no_gaps = $urandom_range(0, 2) == 0;
      send_random();
    end
    no_gaps = 0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_TICK;
    event_type = '0;
    delay_ms = '0;
    repeat_flag = 1'b0;
    payload_tag = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DELIVER;
    cfg_data = '0;
    deliver_on = 0;
    dedup_mask = 16'd7;
    now_ms = '0;
    errors = 0;
    no_gaps = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_fire_and_repeat();
    test_dedup();
    test_full_table();
    test_random_phase(1'b1, 16'h0007);
    test_random_phase(1'b0, 16'hffff);
    test_random_phase(1'b1, 16'h0000);
    test_random_phase(1'b1, 16'($urandom));
    wait_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
